/* src/spqc_pkg.sv */
// ----------------------------------------------------------------------------
// spqc_pkg
// Shared types, constants and arithmetic helpers for the sprite quad corner
// setup pipeline.
// ----------------------------------------------------------------------------
package spqc_pkg;

  localparam int FRAC_BITS = 16;

  // whole degrees and their wrap into 0..359
  localparam int WHOLE_W   = 32 - FRAC_BITS;
  localparam int DEG_W     = WHOLE_W + 2;
  localparam int DEG_OFS   = 360 * ((2 ** (WHOLE_W - 1) + 359) / 360);
  localparam int RCP_SH    = DEG_W + 9;
  localparam longint unsigned RCP_MUL = ((64'd1 << RCP_SH) + 64'd359) / 64'd360;
  localparam int RCP_W     = RCP_SH - 8;
  localparam int MPROD_W   = DEG_W + RCP_W;

  localparam int DEG_FULL  = 360;
  localparam int DEG_QUART = 90;
  localparam int DEG_HALF  = 180;
  localparam int DEG_3Q    = 270;

  localparam int ACC_W     = FRAC_BITS + 20;
  localparam int TRIG_W    = FRAC_BITS + 4;
  localparam int PT_W      = 32 + TRIG_W;

  localparam int NUM_W     = 48;
  localparam int REM_W     = 17;
  localparam int DIV_STAGES = NUM_W;

  localparam logic [16:0] TEX_ONE = 17'h10000;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLAIN = 2'd1,
    KIND_ATLAS = 2'd2,
    KIND_ROT   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_KIND   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_ORIG   = 3'd2,
    REG_PACKED = 3'd3,
    REG_TEX_U  = 3'd4,
    REG_TEX_V  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] offset;
    logic [31:0] orig;
    logic [31:0] packed_size;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] rotation_deg;
    logic [30:0]        quad_width;
    logic [30:0]        quad_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last_corner;
  } out_item_t;

  // Everything an item carries down the pipe; each stage fills its part.
  typedef struct packed {
    logic [31:0]                 px;
    logic [31:0]                 py;
    logic [31:0]                 scx;
    logic [31:0]                 scy;
    logic [29:0]                 hw;
    logic [29:0]                 hh;
    logic [3:0][NUM_W-1:0]       dq;    // numerator, shifted into quotient
    logic [3:0][REM_W-1:0]       drem;
    logic [3:0]                  neg;
    logic [15:0]                 den_x;
    logic [15:0]                 den_y;
    logic [DEG_W-1:0]            wdeg;
    logic [MPROD_W-1:0]          mprod;
    logic [FRAC_BITS-1:0]        frac;
    logic [8:0]                  ks0;
    logic [8:0]                  ks1;
    logic [8:0]                  kc0;
    logic [8:0]                  kc1;
    logic [ACC_W-1:0]            sacc;
    logic [ACC_W-1:0]            cacc;
    logic [TRIG_W-1:0]           sn;
    logic [TRIG_W-1:0]           cs;
    logic [3:0][31:0]            ext;   // lx, lx2, ly, ly2, later scaled
    logic [3:0][63:0]            sprod;
    logic [7:0][PT_W-1:0]        tprod;
    logic [3:0][31:0]            vx;
    logic [3:0][31:0]            vy;
    logic [3:0][16:0]            tu;
    logic [3:0][16:0]            tv;
  } pl_t;

  localparam logic [16:0] SIN_LUT [0:90] = '{
    17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
    17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
    17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
    17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
    17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
    17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
    17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
    17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
    17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
    17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
    17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
    17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
    17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // sine at a whole degree 0..359, signed Q1.16
  function automatic logic signed [17:0] sin_deg(input logic [8:0] k);
    logic [8:0]  idx;
    logic        neg;
    logic [17:0] mag;
    if (k < 9'(DEG_QUART)) begin
      idx = k;
      neg = 1'b0;
    end else if (k < 9'(DEG_HALF)) begin
      idx = 9'(DEG_HALF) - k;
      neg = 1'b0;
    end else if (k < 9'(DEG_3Q)) begin
      idx = k - 9'(DEG_HALF);
      neg = 1'b1;
    end else begin
      idx = 9'(DEG_FULL) - k;
      neg = 1'b1;
    end
    mag = {1'b0, SIN_LUT[idx[6:0]]};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round to nearest, ties up, at FRAC_BITS
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p);
    return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

endpackage

/* src/sprite_quad_corner_setup_unit.sv */
// ----------------------------------------------------------------------------
// sprite_quad_corner_setup_unit
// Sprite placement in, four quad corners (vertex and texture coordinate) out.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  in       | in_valid_i / in_ready_o | in_data_i  (placement request)
//  out      | out_valid_o/ out_ready_i| out_data_o (one corner per beat)
//  cfg      | psel/penable/pwrite     | paddr, pwdata, prdata (APB)
//
// A request passes three front stages, 48 divider stages (one quotient bit
// each), five back-end stages and the corner buffer before its first corner.
// Requests enter every cycle while the pipe is not stalled; the sustained rate
// is set by the four corner beats per request on the output.
// Reset clears all valid bits and the configuration registers. A stall at the
// output holds the whole pipe in place once a finished quad waits behind it.
// ----------------------------------------------------------------------------
module sprite_quad_corner_setup_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  spqc_pkg::in_item_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output spqc_pkg::out_item_t    out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  spqc_pkg::cfg_t cfg;
  spqc_pkg::pl_t  fr_pl, dv_pl, bk_pl;
  logic           fr_v, dv_v, bk_v;
  logic           en, load, take, fin;

  logic                  bv_q;
  logic [1:0]            cnt_q;
  logic [3:0][31:0]      vx_q, vy_q;
  logic [3:0][16:0]      tu_q, tv_q;

  assign pready = 1'b1;

  spqc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  spqc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .cfg_i   (cfg),
    .valid_o (fr_v),
    .pl_o    (fr_pl)
  );

  spqc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .pl_i    (fr_pl),
    .valid_o (dv_v),
    .pl_o    (dv_pl)
  );

  spqc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v),
    .pl_i    (dv_pl),
    .valid_o (bk_v),
    .pl_o    (bk_pl)
  );

  // corner buffer: takes a finished quad when empty or while the last corner leaves
  assign take = bv_q & out_ready_i;
  assign fin  = take & (cnt_q == 2'd3);
  assign load = bk_v & (~bv_q | fin);
  assign en   = ~bk_v | load;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (load) begin
        bv_q  <= 1'b1;
        cnt_q <= 2'd0;
      end else begin
        if (fin) begin
          bv_q <= 1'b0;
        end
        if (take) begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vx_q <= bk_pl.vx;
      vy_q <= bk_pl.vy;
      tu_q <= bk_pl.tu;
      tv_q <= bk_pl.tv;
    end
  end

  assign out_valid_o            = bv_q;
  assign out_data_o.corner      = cnt_q;
  assign out_data_o.vert_x      = vx_q[cnt_q];
  assign out_data_o.vert_y      = vy_q[cnt_q];
  assign out_data_o.tex_u       = tu_q[cnt_q];
  assign out_data_o.tex_v       = tv_q[cnt_q];
  assign out_data_o.last_corner = (cnt_q == 2'd3);

`ifndef SYNTHESIS
  a_corner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cnt_q != 2'd3) |=> (bv_q && cnt_q == $past(cnt_q) + 2'd1))
    else $error("corner index did not advance");

  a_quad_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (bv_q && cnt_q == 2'd0))
    else $error("new quad did not start at bottom-left");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (bk_v && bv_q))
    else $error("pipe stalled without a waiting quad");
`endif

endmodule

/* src/spqc_regs.sv */
// ----------------------------------------------------------------------------
// spqc_regs
// APB register file: region kind, atlas trim geometry and texture bounds.
// ----------------------------------------------------------------------------
module spqc_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output spqc_pkg::cfg_t     cfg_o
);

  spqc_pkg::cfg_t cfg_q;
  logic           wr;

  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        spqc_pkg::REG_KIND:   cfg_q.kind        <= spqc_pkg::kind_e'(pwdata[1:0]);
        spqc_pkg::REG_OFFSET: cfg_q.offset      <= pwdata;
        spqc_pkg::REG_ORIG:   cfg_q.orig        <= pwdata;
        spqc_pkg::REG_PACKED: cfg_q.packed_size <= pwdata;
        spqc_pkg::REG_TEX_U:  cfg_q.tex_u       <= pwdata;
        spqc_pkg::REG_TEX_V:  cfg_q.tex_v       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      spqc_pkg::REG_KIND:   prdata = {30'b0, cfg_q.kind};
      spqc_pkg::REG_OFFSET: prdata = cfg_q.offset;
      spqc_pkg::REG_ORIG:   prdata = cfg_q.orig;
      spqc_pkg::REG_PACKED: prdata = cfg_q.packed_size;
      spqc_pkg::REG_TEX_U:  prdata = cfg_q.tex_u;
      spqc_pkg::REG_TEX_V:  prdata = cfg_q.tex_v;
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/spqc_front.sv */
// ----------------------------------------------------------------------------
// spqc_front
// Three stages: trim numerators and angle reduction product, wrap to whole
// degrees, table lookup with linear interpolation.
// ----------------------------------------------------------------------------
module spqc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  spqc_pkg::in_item_t   item_i,
  input  spqc_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output spqc_pkg::pl_t        pl_o
);

  spqc_pkg::pl_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  logic [2:0]    v_q;

  // stage 1 terms
  logic [15:0] ox, oy, ow, oh, pw, ph, ex, ey;
  logic        atlas, trim_x, trim_y;
  logic signed [17:0] rx, ry;
  logic [16:0] rxm, rym;
  logic signed [spqc_pkg::WHOLE_W-1:0] whole;
  logic [spqc_pkg::DEG_W-1:0] wdeg;
  logic [16:0] u, u2, v, v2;

  always_comb begin
    ox = cfg_i.offset[15:0];
    oy = cfg_i.offset[31:16];
    ow = cfg_i.orig[15:0];
    oh = cfg_i.orig[31:16];
    pw = cfg_i.packed_size[15:0];
    ph = cfg_i.packed_size[31:16];
    ex = (cfg_i.kind == spqc_pkg::KIND_ROT) ? ph : pw;
    ey = (cfg_i.kind == spqc_pkg::KIND_ROT) ? pw : ph;
    atlas  = (cfg_i.kind == spqc_pkg::KIND_ATLAS) || (cfg_i.kind == spqc_pkg::KIND_ROT);
    trim_x = atlas && (ow != 16'd0);
    trim_y = atlas && (oh != 16'd0);
    rx  = $signed({2'b0, ow}) - $signed({2'b0, ox}) - $signed({2'b0, ex});
    ry  = $signed({2'b0, oh}) - $signed({2'b0, oy}) - $signed({2'b0, ey});
    rxm = rx[17] ? 17'(-rx) : rx[16:0];
    rym = ry[17] ? 17'(-ry) : ry[16:0];
    whole = spqc_pkg::WHOLE_W'(item_i.rotation_deg >>> spqc_pkg::FRAC_BITS);
    wdeg  = {{2{whole[spqc_pkg::WHOLE_W-1]}}, whole}
          + spqc_pkg::DEG_W'(spqc_pkg::DEG_OFS);
    u  = {1'b0, cfg_i.tex_u[15:0]};
    u2 = {1'b0, cfg_i.tex_u[31:16]};
    v  = {1'b0, cfg_i.tex_v[15:0]};
    v2 = {1'b0, cfg_i.tex_v[31:16]};

    s1_d       = '0;
    s1_d.px    = item_i.pos_x;
    s1_d.py    = item_i.pos_y;
    s1_d.scx   = item_i.scale_x;
    s1_d.scy   = item_i.scale_y;
    s1_d.hw    = item_i.quad_width[30:1];
    s1_d.hh    = item_i.quad_height[30:1];
    s1_d.dq[0] = trim_x ? {32'b0, ox} * {17'b0, item_i.quad_width} : '0;
    s1_d.dq[1] = trim_x ? {31'b0, rxm} * {17'b0, item_i.quad_width} : '0;
    s1_d.dq[2] = trim_y ? {32'b0, oy} * {17'b0, item_i.quad_height} : '0;
    s1_d.dq[3] = trim_y ? {31'b0, rym} * {17'b0, item_i.quad_height} : '0;
    s1_d.neg   = {trim_y & ry[17], 1'b0, trim_x & rx[17], 1'b0};
    s1_d.den_x = trim_x ? ow : 16'd1;
    s1_d.den_y = trim_y ? oh : 16'd1;
    s1_d.wdeg  = wdeg;
    s1_d.mprod = spqc_pkg::MPROD_W'(wdeg) * spqc_pkg::MPROD_W'(spqc_pkg::RCP_MUL);
    s1_d.frac  = item_i.rotation_deg[spqc_pkg::FRAC_BITS-1:0];
    case (cfg_i.kind)
      spqc_pkg::KIND_NONE: begin
        s1_d.tu = {spqc_pkg::TEX_ONE, spqc_pkg::TEX_ONE, 17'd0, 17'd0};
        s1_d.tv = {17'd0, spqc_pkg::TEX_ONE, spqc_pkg::TEX_ONE, 17'd0};
      end
      spqc_pkg::KIND_ROT: begin
        s1_d.tu = {u, u, u2, u2};
        s1_d.tv = {v, v2, v2, v};
      end
      default: begin
        s1_d.tu = {u2, u, u, u2};
        s1_d.tv = {v, v, v2, v2};
      end
    endcase
  end

  // stage 2: exact wrap to 0..359
  logic [spqc_pkg::DEG_W-1:0] quo, rem;
  logic [8:0] k0;

  always_comb begin
    s2_d = s1_q;
    quo  = spqc_pkg::DEG_W'(s1_q.mprod >> spqc_pkg::RCP_SH);
    rem  = s1_q.wdeg - spqc_pkg::DEG_W'(quo * spqc_pkg::DEG_W'(spqc_pkg::DEG_FULL));
    if (rem >= spqc_pkg::DEG_W'(spqc_pkg::DEG_FULL)) begin
      rem = rem - spqc_pkg::DEG_W'(spqc_pkg::DEG_FULL);
    end
    k0 = rem[8:0];
    s2_d.ks0 = k0;
    s2_d.ks1 = (k0 == 9'(spqc_pkg::DEG_FULL - 1)) ? 9'd0 : k0 + 9'd1;
    s2_d.kc0 = (k0 >= 9'(spqc_pkg::DEG_3Q)) ? k0 - 9'(spqc_pkg::DEG_3Q)
                                            : k0 + 9'(spqc_pkg::DEG_QUART);
    s2_d.kc1 = (k0 >= 9'(spqc_pkg::DEG_3Q - 1)) ? k0 - 9'(spqc_pkg::DEG_3Q - 1)
                                                : k0 + 9'(spqc_pkg::DEG_QUART + 1);
  end

  // stage 3: interpolate between neighboring whole degrees
  logic signed [17:0] sa, sb, ca, cb;
  logic signed [spqc_pkg::ACC_W-1:0] fr;

  always_comb begin
    s3_d = s2_q;
    sa = spqc_pkg::sin_deg(s2_q.ks0);
    sb = spqc_pkg::sin_deg(s2_q.ks1);
    ca = spqc_pkg::sin_deg(s2_q.kc0);
    cb = spqc_pkg::sin_deg(s2_q.kc1);
    fr = spqc_pkg::ACC_W'($signed({1'b0, s2_q.frac}));
    s3_d.sacc = (spqc_pkg::ACC_W'(sa) <<< spqc_pkg::FRAC_BITS)
              + spqc_pkg::ACC_W'(19'(sb) - 19'(sa)) * fr;
    s3_d.cacc = (spqc_pkg::ACC_W'(ca) <<< spqc_pkg::FRAC_BITS)
              + spqc_pkg::ACC_W'(19'(cb) - 19'(ca)) * fr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign valid_o = v_q[2];
  assign pl_o    = s3_q;

endmodule

/* src/spqc_div.sv */
// ----------------------------------------------------------------------------
// spqc_div
// Four-lane restoring divider, one quotient bit per stage, fully pipelined.
// ----------------------------------------------------------------------------
module spqc_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  spqc_pkg::pl_t   pl_i,
  output logic            valid_o,
  output spqc_pkg::pl_t   pl_o
);

  spqc_pkg::pl_t                   st_q [spqc_pkg::DIV_STAGES];
  logic [spqc_pkg::DIV_STAGES-1:0] v_q;

  function automatic spqc_pkg::pl_t div_step(input spqc_pkg::pl_t p);
    spqc_pkg::pl_t               r;
    logic [spqc_pkg::REM_W-1:0]  t;
    logic [spqc_pkg::REM_W-1:0]  dn;
    r = p;
    for (int l = 0; l < 4; l++) begin
      dn = {1'b0, (l < 2) ? p.den_x : p.den_y};
      t  = {p.drem[l][spqc_pkg::REM_W-2:0], p.dq[l][spqc_pkg::NUM_W-1]};
      if (t >= dn) begin
        r.drem[l] = t - dn;
        r.dq[l]   = {p.dq[l][spqc_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r.drem[l] = t;
        r.dq[l]   = {p.dq[l][spqc_pkg::NUM_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[spqc_pkg::DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(pl_i);
    end
  end

  for (genvar i = 1; i < spqc_pkg::DIV_STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= div_step(st_q[i-1]);
      end
    end
  end

  assign valid_o = v_q[spqc_pkg::DIV_STAGES-1];
  assign pl_o    = st_q[spqc_pkg::DIV_STAGES-1];

endmodule

/* src/spqc_back.sv */
// ----------------------------------------------------------------------------
// spqc_back
// Extents from quotients, scaling, rotation and translation: five stages,
// a register after every multiply.
// ----------------------------------------------------------------------------
module spqc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  spqc_pkg::pl_t   pl_i,
  output logic            valid_o,
  output spqc_pkg::pl_t   pl_o
);

  spqc_pkg::pl_t b1_d, b1_q, b2_d, b2_q, b3_d, b3_q, b4_d, b4_q, b5_d, b5_q;
  logic [4:0]    v_q;

  // B1: signed quotients into local extents, trig rounding
  logic signed [48:0] qs [4];
  logic signed [49:0] e  [4];
  logic signed [spqc_pkg::ACC_W-1:0] rs, rc;

  always_comb begin
    b1_d = pl_i;
    for (int l = 0; l < 4; l++) begin
      qs[l] = pl_i.neg[l] ? -$signed({1'b0, pl_i.dq[l]}) : $signed({1'b0, pl_i.dq[l]});
    end
    e[0] = 50'(qs[0]) - $signed({20'b0, pl_i.hw});
    e[1] = $signed({20'b0, pl_i.hw}) - 50'(qs[1]);
    e[2] = 50'(qs[2]) - $signed({20'b0, pl_i.hh});
    e[3] = $signed({20'b0, pl_i.hh}) - 50'(qs[3]);
    for (int l = 0; l < 4; l++) begin
      b1_d.ext[l] = spqc_pkg::sat32(64'(e[l]));
    end
    rs = $signed(pl_i.sacc) + $signed(spqc_pkg::ACC_W'(32768));
    rc = $signed(pl_i.cacc) + $signed(spqc_pkg::ACC_W'(32768));
    b1_d.sn = spqc_pkg::TRIG_W'(rs >>> 16);
    b1_d.cs = spqc_pkg::TRIG_W'(rc >>> 16);
  end

  // B2: scale products
  always_comb begin
    b2_d = b1_q;
    for (int l = 0; l < 4; l++) begin
      b2_d.sprod[l] = 64'($signed(b1_q.ext[l]))
                    * 64'($signed((l < 2) ? b1_q.scx : b1_q.scy));
    end
  end

  // B3: round and saturate scaled extents
  always_comb begin
    b3_d = b2_q;
    for (int l = 0; l < 4; l++) begin
      b3_d.ext[l] = spqc_pkg::sat32(spqc_pkg::rnd_shift($signed(b2_q.sprod[l])));
    end
  end

  // B4: extent times cos and sin, pairs per extent
  always_comb begin
    b4_d = b3_q;
    for (int l = 0; l < 4; l++) begin
      b4_d.tprod[2*l]   = spqc_pkg::PT_W'($signed(b3_q.ext[l]))
                        * spqc_pkg::PT_W'($signed(b3_q.cs));
      b4_d.tprod[2*l+1] = spqc_pkg::PT_W'($signed(b3_q.ext[l]))
                        * spqc_pkg::PT_W'($signed(b3_q.sn));
    end
  end

  // B5: corner sums; BL (lx,ly), UL (lx,ly2), UR (lx2,ly2), BR (lx2,ly)
  logic signed [63:0] acs, asn, bcs, bsn;
  int ia, ib;

  always_comb begin
    b5_d = b4_q;
    acs = '0;
    asn = '0;
    bcs = '0;
    bsn = '0;
    for (int k = 0; k < 4; k++) begin
      ia  = (k == 2 || k == 3) ? 1 : 0;
      ib  = (k == 1 || k == 2) ? 1 : 0;
      acs = spqc_pkg::rnd_shift(64'($signed(b4_q.tprod[2*ia])));
      asn = spqc_pkg::rnd_shift(64'($signed(b4_q.tprod[2*ia+1])));
      bcs = spqc_pkg::rnd_shift(64'($signed(b4_q.tprod[4+2*ib])));
      bsn = spqc_pkg::rnd_shift(64'($signed(b4_q.tprod[5+2*ib])));
      b5_d.vx[k] = spqc_pkg::sat32(acs - bsn + 64'($signed(b4_q.px)));
      b5_d.vy[k] = spqc_pkg::sat32(bcs + asn + 64'($signed(b4_q.py)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b4_q <= b4_d;
      b5_q <= b5_d;
    end
  end

  assign valid_o = v_q[4];
  assign pl_o    = b5_q;

endmodule

/* tb/sprite_quad_corner_setup_unit_test.sv */
// ----------------------------------------------------------------------------
// sprite_quad_corner_setup_unit_test
// Drives random and directed placement requests through the quad corner setup
// unit under several region settings and checks every corner beat against a
// local fixed-point prediction of vertex and texture coordinates.
// ----------------------------------------------------------------------------
module sprite_quad_corner_setup_unit_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  spqc_pkg::in_item_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  spqc_pkg::out_item_t  out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [4:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  sprite_quad_corner_setup_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // shadow copy of the register file
  logic [1:0]  shd_kind;
  logic [31:0] shd_offset, shd_orig, shd_packed, shd_tex_u, shd_tex_v;

  spqc_pkg::in_item_t  request_q[$];
  spqc_pkg::out_item_t corner_q[$];
  int        fail_cnt;
  int        idle_cnt;
  bit        stim_done;

  const int SIN_TAB[91] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sine_at(longint k);
    longint q, r;
    q = k / 90;
    r = k % 90;
    case (q)
      0: return SIN_TAB[r];
      1: return SIN_TAB[90 - r];
      2: return -SIN_TAB[r];
      default: return -SIN_TAB[90 - r];
    endcase
  endfunction

  function automatic longint sine_lerp(longint whole, longint frac, longint shift);
    longint k0, k1, s0, s1;
    k0 = (whole + shift) % 360;
    if (k0 < 0) k0 += 360;
    k1 = (k0 + 1) % 360;
    s0 = sine_at(k0);
    s1 = sine_at(k1);
    return round_q(s0 * (64'sd1 <<< spqc_pkg::FRAC_BITS) + (s1 - s0) * frac, 16);
  endfunction

  task automatic predict_corners(input spqc_pkg::in_item_t rq);
    longint px, py, scx, scy, ang, w, h, lx, lx2, ly, ly2;
    longint ox, oy, ow, oh, pw, ph, ex, ey, whole, frac, cs, sn, a, b;
    longint ax[2], ay[2], tu[4], tv[4];
    longint u, u2, v, v2;
    bit rot;
    spqc_pkg::out_item_t c;
    px = rq.pos_x; py = rq.pos_y; scx = rq.scale_x; scy = rq.scale_y;
    ang = rq.rotation_deg;
    w = rq.quad_width; h = rq.quad_height;
    lx2 = w / 2; ly2 = h / 2; lx = -lx2; ly = -ly2;
    rot = (shd_kind == spqc_pkg::KIND_ROT);
    u = shd_tex_u[15:0]; u2 = shd_tex_u[31:16];
    v = shd_tex_v[15:0]; v2 = shd_tex_v[31:16];
    if (shd_kind >= spqc_pkg::KIND_ATLAS) begin
      ox = shd_offset[15:0]; oy = shd_offset[31:16];
      ow = shd_orig[15:0];   oh = shd_orig[31:16];
      pw = shd_packed[15:0]; ph = shd_packed[31:16];
      ex = rot ? ph : pw; ey = rot ? pw : ph;
      // zero original size leaves that axis untrimmed
      if (ow != 0) begin
        lx += ox * w / ow;
        lx2 -= (ow - ox - ex) * w / ow;
      end
      if (oh != 0) begin
        ly += oy * h / oh;
        ly2 -= (oh - oy - ey) * h / oh;
      end
    end
    ax[0] = clamp32(round_q(clamp32(lx) * scx, spqc_pkg::FRAC_BITS));
    ax[1] = clamp32(round_q(clamp32(lx2) * scx, spqc_pkg::FRAC_BITS));
    ay[0] = clamp32(round_q(clamp32(ly) * scy, spqc_pkg::FRAC_BITS));
    ay[1] = clamp32(round_q(clamp32(ly2) * scy, spqc_pkg::FRAC_BITS));
    whole = ang >>> spqc_pkg::FRAC_BITS;
    frac = ang & ((64'sd1 <<< spqc_pkg::FRAC_BITS) - 1);
    sn = sine_lerp(whole, frac, 0);
    cs = sine_lerp(whole, frac, 90);
    if (shd_kind == spqc_pkg::KIND_NONE) begin
      tu = '{0, 0, 65536, 65536};
      tv = '{0, 65536, 65536, 0};
    end else if (rot) begin
      tu = '{u2, u2, u, u};
      tv = '{v, v2, v2, v};
    end else begin
      tu = '{u2, u, u, u2};
      tv = '{v2, v2, v, v};
    end
    for (int k = 0; k < 4; k++) begin
      a = ax[(k >= 2) ? 1 : 0];
      b = ay[(k == 1 || k == 2) ? 1 : 0];
      c.corner = k[1:0];
      c.vert_x = clamp32(round_q(a * cs, spqc_pkg::FRAC_BITS)
                         - round_q(b * sn, spqc_pkg::FRAC_BITS) + px);
      c.vert_y = clamp32(round_q(b * cs, spqc_pkg::FRAC_BITS)
                         + round_q(a * sn, spqc_pkg::FRAC_BITS) + py);
      c.tex_u = tu[k][16:0];
      c.tex_v = tv[k][16:0];
      c.last_corner = (k == 3);
      corner_q.push_back(c);
    end
  endtask

  // driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_corners(in_data_i);
        gap = $urandom_range(0, 5);
        if (gap == 0 && request_q.size() > 0) begin
          in_data_i  <= request_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= 0;
        end else begin
          in_valid_i <= 1'b0;
          send_gap   <= (gap == 0) ? 0 : gap - 1;
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (request_q.size() > 0) begin
          in_data_i  <= request_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    spqc_pkg::out_item_t want;
    int gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (corner_q.size() == 0) begin
          $display("%0t: unexpected corner %p", $time, out_data_o);
          fail_cnt++;
        end else begin
          want = corner_q.pop_front();
          if (out_data_o !== want) begin
            $display("%0t: corner mismatch expected %p actual %p", $time, want, out_data_o);
            fail_cnt++;
          end
        end
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          recv_gap    <= gap - 1;
        end
      end else if (!out_ready_i) begin
        if (recv_gap > 0) recv_gap <= recv_gap - 1;
        else out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (stim_done && corner_q.size() == 0 && request_q.size() == 0)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input spqc_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      spqc_pkg::REG_KIND:   shd_kind   = val[1:0];
      spqc_pkg::REG_OFFSET: shd_offset = val;
      spqc_pkg::REG_ORIG:   shd_orig   = val;
      spqc_pkg::REG_PACKED: shd_packed = val;
      spqc_pkg::REG_TEX_U:  shd_tex_u  = val;
      default:              shd_tex_v  = val;
    endcase
  endtask

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid_i || corner_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  // moderate values keep most vertices out of saturation
  function automatic spqc_pkg::in_item_t rand_request();
    spqc_pkg::in_item_t r;
    if ($urandom_range(0, 4) == 0) begin
      r.pos_x = rand_word(); r.pos_y = rand_word();
      r.scale_x = rand_word(); r.scale_y = rand_word();
      r.rotation_deg = rand_word();
      r.quad_width = 31'(rand_word()); r.quad_height = 31'(rand_word());
    end else begin
      r.pos_x = $signed($urandom()) >>> $urandom_range(4, 12);
      r.pos_y = $signed($urandom()) >>> $urandom_range(4, 12);
      r.scale_x = $signed($urandom()) >>> $urandom_range(12, 16);
      r.scale_y = $signed($urandom()) >>> $urandom_range(12, 16);
      r.rotation_deg = $urandom();
      r.quad_width = 31'($urandom() >> $urandom_range(4, 10));
      r.quad_height = 31'($urandom() >> $urandom_range(4, 10));
    end
    return r;
  endfunction

  task automatic load_config(input logic [1:0] kind, input logic [31:0] ofs,
                             input logic [31:0] orig, input logic [31:0] pk,
                             input logic [31:0] tu, input logic [31:0] tv);
    reg_write(spqc_pkg::REG_KIND, {30'd0, kind});
    reg_write(spqc_pkg::REG_OFFSET, ofs);
    reg_write(spqc_pkg::REG_ORIG, orig);
    reg_write(spqc_pkg::REG_PACKED, pk);
    reg_write(spqc_pkg::REG_TEX_U, tu);
    reg_write(spqc_pkg::REG_TEX_V, tv);
  endtask

  initial begin
    spqc_pkg::in_item_t r;
    logic [15:0] ow, oh;
    fail_cnt  = 0;
    stim_done = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    shd_kind = '0; shd_offset = '0; shd_orig = '0; shd_packed = '0;
    shd_tex_u = '0; shd_tex_v = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all-zero request, field extremes, angle corners
    r = '0; request_q.push_back(r);
    r = '1; request_q.push_back(r);
    r = '0;
    r.scale_x = 32'h10000; r.scale_y = 32'h10000;
    r.quad_width = 31'h7fffffff; r.quad_height = 31'h7fffffff;
    request_q.push_back(r);
    for (int d = -2; d <= 6; d++) begin
      r = '0;
      r.scale_x = 32'h10000; r.scale_y = 32'h20000;
      r.quad_width = 31'h200000; r.quad_height = 31'h100000;
      r.rotation_deg = (d * 90) <<< 16 | (d[0] ? 32'h8000 : 32'h0);
      request_q.push_back(r);
    end
    r.pos_x = 32'h7fffffff; r.pos_y = 32'h80000000;
    r.scale_x = 32'h7fffffff; r.scale_y = 32'h80000000;
    r.rotation_deg = 32'h7fffffff;
    request_q.push_back(r);
    r.rotation_deg = 32'h80000000;
    request_q.push_back(r);
    wait_idle();

    // plain region, atlas, rotated atlas, zero original size, no region
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_config(spqc_pkg::KIND_PLAIN, 32'h0, 32'h0, 32'h0, 32'hffff0000,
                       32'h0000ffff);
        1: load_config(spqc_pkg::KIND_ATLAS, 32'h00040002, 32'h00400020, 32'h0030001c,
                       32'h40002000, 32'h80001000);
        2: load_config(spqc_pkg::KIND_ROT, 32'h00040002, 32'h00400020, 32'h001c0030,
                       32'hc0004000, 32'h20006000);
        3: load_config(spqc_pkg::KIND_ATLAS, 32'hffffffff, 32'h0, 32'hffffffff,
                       32'hffffffff, 32'hffffffff);
        4: load_config(spqc_pkg::KIND_ROT, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0,
                       32'h0);
        default: load_config(spqc_pkg::KIND_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      endcase
      r = '0;
      r.scale_x = 32'h10000; r.scale_y = 32'h10000;
      r.quad_width = 31'h400000; r.quad_height = 31'h200000;
      request_q.push_back(r);
      r.rotation_deg = 32'h2d0000;
      r.quad_width = 31'h7fffffff;
      request_q.push_back(r);
      wait_idle();
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      ow = (ph % 4 == 3) ? 16'h0 : 16'($urandom_range(1, 65535));
      oh = (ph % 4 == 2) ? 16'h0 : 16'($urandom_range(1, 65535));
      load_config(2'(ph % 4), $urandom(), {oh, ow}, $urandom(), $urandom(), $urandom());
      for (int n = 0; n < 40; n++) request_q.push_back(rand_request());
      wait_idle();
    end

    stim_done = 1'b1;
    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
